// ===== hdl/rgb_to_hsv_macros.svh =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_macros
// assertion macros for the rgb to hsv block
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_MACROS_SVH
`define RGB_TO_HSV_MACROS_SVH

// same-cycle implication, checked outside reset
`define RGBHSV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb_to_hsv check failed");

// next-cycle implication, checked outside reset
`define RGBHSV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb_to_hsv check failed");

`endif

// ===== hdl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared types and constants of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // default channel width in fraction bits
  localparam int CHANNEL_BITS_DEF = 16;

  // which channel is the largest, and so which sextant base applies
  typedef enum logic [1:0] {
    BASE_RED   = 2'd0,
    BASE_GREEN = 2'd1,
    BASE_BLUE  = 2'd2
  } hue_base_t;

  // per-item control carried from front to back
  typedef struct packed {
    logic      grey;  // delta is zero: hue and saturation are zero
    logic      neg;   // hue difference is negative
    hue_base_t base;
  } hsv_ctl_t;

endpackage

// ===== hdl/rgb_to_hsv.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv
// pixel converter from red, green, blue to hue, saturation and value
// ----------------------------------------------------------------------------
// Usage:
//   An item (red, green, blue) is taken at a rising edge where start is high
//   and busy is low. Each result (hue, saturation, value) is shown for one
//   cycle with strobe high; the receiver takes it then and cannot hold it.
//   Path: front register, queue, one divider stage per quotient bit
//   (CHANNEL_BITS + 1 of them), then the hue offset register.
//   Throughput: one item per cycle; both dividers are fully pipelined, one
//   quotient bit per stage, so busy stays low in steady use.
//   Reset clears the front, the queue and all stage valid flags; items in
//   flight are dropped and no strobe follows.
//   Hue is in sextants, 0 up to below 6, and saturation 1.0 reads as 1 << CHANNEL_BITS.
// ----------------------------------------------------------------------------
module rgb_to_hsv #(
  parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [CHANNEL_BITS-1:0]   red,
  input  logic [CHANNEL_BITS-1:0]   green,
  input  logic [CHANNEL_BITS-1:0]   blue,
  output logic                      strobe,
  output logic [CHANNEL_BITS+2:0]   hue,
  output logic [CHANNEL_BITS:0]     saturation,
  output logic [CHANNEL_BITS-1:0]   value
);
  import rgbhsv_pkg::*;
`include "rgb_to_hsv_macros.svh"

  localparam int W     = CHANNEL_BITS;
  localparam int QBITS = 3 * W + $bits(hsv_ctl_t);

  logic         take, f_vld, q_full, q_pop;
  logic [W-1:0] f_vmax, f_delta, f_mag, b_vmax, b_delta, b_mag;
  hsv_ctl_t     f_ctl, b_ctl;
  logic [QBITS-1:0] q_rdata;

  assign take = start && !busy;
  assign busy = q_full;

  // front: classify
  rgbhsv_front #(.W(W)) u_front (
    .clk(clk), .rst(rst), .take(take),
    .red(red), .green(green), .blue(blue),
    .vld(f_vld), .vmax(f_vmax), .delta(f_delta), .mag(f_mag), .ctl(f_ctl)
  );

  // queue between front and back
  rgbhsv_queue #(.DATA_BITS(QBITS)) u_queue (
    .clk(clk), .rst(rst), .push(f_vld),
    .wdata({f_vmax, f_delta, f_mag, f_ctl}),
    .full(q_full), .pop(q_pop), .rdata(q_rdata)
  );

  assign {b_vmax, b_delta, b_mag, b_ctl} = q_rdata;

  // back: dividers and hue offset
  rgbhsv_back #(.W(W)) u_back (
    .clk(clk), .rst(rst), .in_vld(q_pop),
    .vmax(b_vmax), .delta(b_delta), .mag(b_mag), .ctl(b_ctl),
    .strobe(strobe), .hue(hue), .saturation(saturation), .value(value)
  );

  // checks
  `RGBHSV_ASSERT_NOW(a_sat_range, clk, rst, strobe, saturation <= ((W+1)'(1) << W))
  `RGBHSV_ASSERT_NOW(a_hue_range, clk, rst, strobe, hue < ((W+3)'(6) << W))
  `RGBHSV_ASSERT_NOW(a_grey_hue, clk, rst, strobe && (saturation == '0), hue == '0)
  `RGBHSV_ASSERT_NEXT(a_pop_flows, clk, rst, q_pop, u_back.st_vld[0])

endmodule

// ===== hdl/rgbhsv_front.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_front
// accepts a pixel, finds max, min and delta, and classifies the hue sextant
// ----------------------------------------------------------------------------
module rgbhsv_front #(
  parameter int W = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  logic [W-1:0]         red,
  input  logic [W-1:0]         green,
  input  logic [W-1:0]         blue,
  output logic                 vld,
  output logic [W-1:0]         vmax,
  output logic [W-1:0]         delta,
  output logic [W-1:0]         mag,
  output rgbhsv_pkg::hsv_ctl_t ctl
);
  import rgbhsv_pkg::*;

  logic [W-1:0] mx, mn, a, b, mag_next;
  hsv_ctl_t     ctl_next;

  // max and min with ties going to red, then green
  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  // pick the difference for the sextant of the largest channel
  always_comb begin
    if (red == mx) begin
      ctl_next.base = BASE_RED;
      a = green;
      b = blue;
    end else if (green == mx) begin
      ctl_next.base = BASE_GREEN;
      a = blue;
      b = red;
    end else begin
      ctl_next.base = BASE_BLUE;
      a = red;
      b = green;
    end
    ctl_next.neg  = (b > a);
    ctl_next.grey = (mx == mn);
    mag_next      = ctl_next.neg ? (b - a) : (a - b);
  end

  // front register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= take;
    end
    if (take) begin
      vmax  <= mx;
      delta <= mx - mn;
      mag   <= mag_next;
      ctl   <= ctl_next;
    end
  end

endmodule

// ===== hdl/rgbhsv_queue.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_queue
// two-entry queue between the front and the divider pipeline
// ----------------------------------------------------------------------------
module rgbhsv_queue #(
  parameter int DATA_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] wdata,
  output logic                 full,
  output logic                 pop,
  output logic [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2];
  logic                 wptr, rptr;
  logic [1:0]           count;

  // the back part never stalls, so any waiting item leaves at once
  assign pop   = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign rdata = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/rgbhsv_back.sv =====
// ----------------------------------------------------------------------------
// rgbhsv_back
// two pipelined restoring dividers, one quotient bit per stage, then hue fix
// ----------------------------------------------------------------------------
module rgbhsv_back #(
  parameter int W = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic [W-1:0]         vmax,
  input  logic [W-1:0]         delta,
  input  logic [W-1:0]         mag,
  input  rgbhsv_pkg::hsv_ctl_t ctl,
  output logic                 strobe,
  output logic [W+2:0]         hue,
  output logic [W:0]           saturation,
  output logic [W-1:0]         value
);
  import rgbhsv_pkg::*;

  localparam int STAGES = W + 1;

  // per-stage registers
  logic           st_vld [STAGES];
  logic [W-1:0]   st_vmax [STAGES];
  logic [W-1:0]   st_delta [STAGES];
  logic [W-1:0]   s_rem [STAGES];
  logic [W-1:0]   h_rem [STAGES];
  logic [W:0]     s_q [STAGES];
  logic [W:0]     h_q [STAGES];
  hsv_ctl_t       st_ctl [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [W:0] s_t, h_t;
    logic       s_ge, h_ge;
    logic [W:0] s_q_in, h_q_in;
    logic [W:0] s_diff, h_diff;

    // trial subtract for this quotient bit
    if (s == 0) begin : g_first
      assign s_t    = {1'b0, delta};
      assign h_t    = {1'b0, mag};
      assign s_q_in = '0;
      assign h_q_in = '0;
    end else begin : g_next
      assign s_t    = {s_rem[s-1], 1'b0};
      assign h_t    = {h_rem[s-1], 1'b0};
      assign s_q_in = s_q[s-1];
      assign h_q_in = h_q[s-1];
    end

    assign s_ge   = (s_t >= {1'b0, (s == 0) ? vmax : st_vmax[(s == 0) ? 0 : s-1]});
    assign h_ge   = (h_t >= {1'b0, (s == 0) ? delta : st_delta[(s == 0) ? 0 : s-1]});
    assign s_diff = s_t - {1'b0, (s == 0) ? vmax : st_vmax[(s == 0) ? 0 : s-1]};
    assign h_diff = h_t - {1'b0, (s == 0) ? delta : st_delta[(s == 0) ? 0 : s-1]};

    // stage register
    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[s] <= 1'b0;
      end else begin
        st_vld[s] <= (s == 0) ? in_vld : st_vld[(s == 0) ? 0 : s-1];
      end
      s_rem[s] <= s_ge ? s_diff[W-1:0] : s_t[W-1:0];
      h_rem[s] <= h_ge ? h_diff[W-1:0] : h_t[W-1:0];
      s_q[s]   <= {s_q_in[W-1:0], s_ge};
      h_q[s]   <= {h_q_in[W-1:0], h_ge};
      if (s == 0) begin
        st_vmax[s]  <= vmax;
        st_delta[s] <= delta;
        st_ctl[s]   <= ctl;
      end else begin
        st_vmax[s]  <= st_vmax[(s == 0) ? 0 : s-1];
        st_delta[s] <= st_delta[(s == 0) ? 0 : s-1];
        st_ctl[s]   <= st_ctl[(s == 0) ? 0 : s-1];
      end
    end
  end

  // sextant offset and wrap of a negative hue
  logic [W+2:0] q_ext, base_off, hue_next;
  hsv_ctl_t     c_last;

  assign c_last = st_ctl[STAGES-1];
  assign q_ext  = {2'b00, h_q[STAGES-1]};

  always_comb begin
    case (c_last.base)
      BASE_GREEN: base_off = (W+3)'(2) << W;
      BASE_BLUE:  base_off = (W+3)'(4) << W;
      default:    base_off = '0;
    endcase
    if (c_last.grey) begin
      hue_next = '0;
    end else if (c_last.neg && (c_last.base == BASE_RED)) begin
      // below red wraps round by six sextants
      hue_next = ((W+3)'(6) << W) - q_ext;
    end else if (c_last.neg) begin
      hue_next = base_off - q_ext;
    end else begin
      hue_next = base_off + q_ext;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= st_vld[STAGES-1];
    end
    hue        <= hue_next;
    saturation <= c_last.grey ? '0 : s_q[STAGES-1];
    value      <= st_vmax[STAGES-1];
  end

endmodule
